>>> design/tos_pkg.sv
// ----------------------------------------------------------------------------
// tos_pkg
// Shared types and constants for the order slicer: request and result
// layouts, status codes and sequencer states.
// ----------------------------------------------------------------------------
package tos_pkg;

  // Fixed field widths
  localparam int ID_W    = 32;
  localparam int QTY_W   = 32;
  localparam int SEQ_W   = 32;
  localparam int TIME_W  = 48;
  localparam int LIMIT_W = 7;

  // Signed window difference and divider dividend width
  localparam int DIFF_W    = TIME_W + 1;
  localparam int DIV_STEPS = DIFF_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ID   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_QTY,
    S_DIV_TIME,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic              eligible;
    logic [QTY_W-1:0]  remaining_qty;
    logic [TIME_W-1:0] window_start;
    logic [TIME_W-1:0] window_end;
    logic [ID_W-1:0]   parent_id;
    logic              order_side;
    logic [ID_W-1:0]   first_child_id;
    logic [SEQ_W-1:0]  first_sequence;
  } request_t;

  typedef struct packed {
    logic [ID_W-1:0]   child_id;
    logic [ID_W-1:0]   child_parent_id;
    logic              child_side;
    logic [QTY_W-1:0]  child_qty;
    logic [TIME_W-1:0] child_time;
    logic [SEQ_W-1:0]  child_sequence;
    status_t           status;
    logic              last;
  } result_t;

endpackage

>>> design/twap_order_slicer.sv
// ----------------------------------------------------------------------------
// twap_order_slicer
// Splits one parent order into evenly sized, evenly timed market children.
// ----------------------------------------------------------------------------
// A parent request is taken when start is high and busy is low. Results
// appear one per cycle on result, each marked by result_strobe for a single
// cycle; the receiver cannot hold them off, so it must take every strobe.
// An ineligible parent gives no result and leaves the block idle. A parent
// with a zero first id or sequence, zero quantity or an id or sequence
// range overflow gives one error result, registered from the check state,
// with last set. A good parent keeps busy high through the check state,
// then two 49-step passes of a shared restoring divider (quantity by n,
// then window length by n), then n children, one per cycle, where
// n = min(quantity, slice limit). The slice limit is written through the
// cfg channel while the block is idle; 0 reads as 1 and values above
// MAX_SLICES saturate.
// ----------------------------------------------------------------------------
module twap_order_slicer #(
  parameter int MAX_SLICES = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  // parent request
  input  logic                             start,
  output logic                             busy,
  input  tos_pkg::request_t                request,
  // child results
  output logic                             result_strobe,
  output tos_pkg::result_t                 result,
  // slice limit register
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tos_pkg::LIMIT_W-1:0]      cfg_data
);

  localparam int CNT_W = $clog2(MAX_SLICES + 1);
  localparam int IDC_W = tos_pkg::ID_W + 1;
  localparam int SQC_W = tos_pkg::SEQ_W + 1;
  localparam int DW    = tos_pkg::DIFF_W;

  tos_pkg::state_t state, state_next;

  // Configuration
  logic [tos_pkg::LIMIT_W-1:0] slice_limit;

  // Latched parent
  logic [tos_pkg::QTY_W-1:0]   parent_qty;
  logic [tos_pkg::TIME_W-1:0]  parent_start;
  logic [tos_pkg::ID_W-1:0]    parent_id;
  logic                        parent_side;
  logic [tos_pkg::ID_W-1:0]    first_id;
  logic [tos_pkg::SEQ_W-1:0]   first_seq;
  logic [DW-1:0]               window_diff;

  // Slicing state
  logic [CNT_W-1:0]            slice_total;
  logic [CNT_W-1:0]            slice_index;
  logic [tos_pkg::QTY_W-1:0]   base_share;
  logic [CNT_W-1:0]            extra_count;
  logic [tos_pkg::TIME_W-1:0]  slot_interval;
  logic [tos_pkg::ID_W-1:0]    cur_id;
  logic [tos_pkg::SEQ_W-1:0]   cur_seq;
  logic [tos_pkg::TIME_W-1:0]  cur_time;

  // Shared divider
  logic [DW-1:0]               div_num;
  logic [CNT_W-1:0]            div_rem;
  logic [tos_pkg::STEP_W-1:0]  div_cnt;
  logic [CNT_W:0]              div_part;
  logic                        div_ge;
  logic [CNT_W-1:0]            div_rem_next;
  logic [DW-1:0]               div_num_next;
  logic                        div_last;

  // Combinational helpers
  logic                        accept;
  logic [CNT_W-1:0]            limit_sat;
  logic [CNT_W-1:0]            slice_req;
  logic                        bad_id;
  logic                        id_over;
  logic                        seq_over;
  logic                        emit_last;
  logic                        extra_bit;
  logic [DW-1:0]               diff_mag;
  logic [DW-1:0]               quot_signed;

  // Saturate the limit and clip it to the parent quantity
  always_comb begin
    priority if (slice_limit == '0) begin
      limit_sat = CNT_W'(1);
    end else if (slice_limit > tos_pkg::LIMIT_W'(MAX_SLICES)) begin
      limit_sat = CNT_W'(MAX_SLICES);
    end else begin
      limit_sat = CNT_W'(slice_limit);
    end
    if (request.remaining_qty < tos_pkg::QTY_W'(limit_sat)) begin
      slice_req = CNT_W'(request.remaining_qty);
    end else begin
      slice_req = limit_sat;
    end
  end

  // Parent checks
  assign bad_id   = (first_id == '0) || (first_seq == '0);
  assign id_over  = ({1'b0, first_id} + IDC_W'(slice_total - CNT_W'(1)))
                    > IDC_W'({tos_pkg::ID_W{1'b1}});
  assign seq_over = ({1'b0, first_seq} + SQC_W'(slice_total - CNT_W'(1)))
                    > SQC_W'({tos_pkg::SEQ_W{1'b1}});

  // One restoring division step
  always_comb begin
    div_part     = {div_rem, div_num[DW-1]};
    div_ge       = div_part >= {1'b0, slice_total};
    div_rem_next = div_ge ? CNT_W'(div_part - {1'b0, slice_total})
                          : CNT_W'(div_part);
    div_num_next = {div_num[DW-2:0], div_ge};
    div_last     = div_cnt == tos_pkg::STEP_W'(tos_pkg::DIV_STEPS - 1);
  end

  assign diff_mag    = window_diff[DW-1] ? (~window_diff + DW'(1)) : window_diff;
  assign quot_signed = window_diff[DW-1] ? (~div_num_next + DW'(1)) : div_num_next;
  assign emit_last   = slice_index == (slice_total - CNT_W'(1));
  assign extra_bit   = slice_index < extra_count;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tos_pkg::S_IDLE: begin
        if (accept && request.eligible) state_next = tos_pkg::S_CHECK;
      end
      tos_pkg::S_CHECK: begin
        if (bad_id || slice_total == '0 || id_over || seq_over) begin
          state_next = tos_pkg::S_IDLE;
        end else begin
          state_next = tos_pkg::S_DIV_QTY;
        end
      end
      tos_pkg::S_DIV_QTY: begin
        if (div_last) state_next = tos_pkg::S_DIV_TIME;
      end
      tos_pkg::S_DIV_TIME: begin
        if (div_last) state_next = tos_pkg::S_EMIT;
      end
      tos_pkg::S_EMIT: begin
        if (emit_last) state_next = tos_pkg::S_IDLE;
      end
      default: state_next = tos_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    busy      = state != tos_pkg::S_IDLE;
    cfg_ready = state == tos_pkg::S_IDLE;
    accept    = start && (state == tos_pkg::S_IDLE);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tos_pkg::S_IDLE;
      slice_limit   <= tos_pkg::LIMIT_W'(1);
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      if (cfg_valid && cfg_ready) slice_limit <= cfg_data;
      result_strobe <= ((state == tos_pkg::S_CHECK) &&
                        (bad_id || slice_total == '0 || id_over || seq_over)) ||
                       (state == tos_pkg::S_EMIT);
    end
  end

  // Slicing counters
  always_ff @(posedge clk) begin
    if (rst) begin
      slice_total <= '0;
      slice_index <= '0;
      extra_count <= '0;
      base_share  <= '0;
      slot_interval <= '0;
      div_cnt     <= '0;
    end else begin
      unique case (state)
        tos_pkg::S_IDLE: begin
          if (accept) slice_total <= slice_req;
          div_cnt <= '0;
        end
        tos_pkg::S_CHECK: begin
          div_cnt <= '0;
        end
        tos_pkg::S_DIV_QTY: begin
          div_cnt <= div_last ? '0 : div_cnt + tos_pkg::STEP_W'(1);
          if (div_last) begin
            base_share  <= div_num_next[tos_pkg::QTY_W-1:0];
            extra_count <= div_rem_next;
          end
        end
        tos_pkg::S_DIV_TIME: begin
          div_cnt <= div_last ? '0 : div_cnt + tos_pkg::STEP_W'(1);
          if (div_last) begin
            slot_interval <= quot_signed[tos_pkg::TIME_W-1:0];
            slice_index   <= '0;
          end
        end
        tos_pkg::S_EMIT: begin
          slice_index <= emit_last ? '0 : slice_index + CNT_W'(1);
        end
        default: begin
          div_cnt <= '0;
        end
      endcase
    end
  end

  // Payload: latch the parent, run the divider, build results
  always_ff @(posedge clk) begin
    unique case (state)
      tos_pkg::S_IDLE: begin
        if (accept) begin
          parent_qty   <= request.remaining_qty;
          parent_start <= request.window_start;
          parent_id    <= request.parent_id;
          parent_side  <= request.order_side;
          first_id     <= request.first_child_id;
          first_seq    <= request.first_sequence;
          window_diff  <= {1'b0, request.window_end} - {1'b0, request.window_start};
        end
      end
      tos_pkg::S_CHECK: begin
        div_num <= DW'(parent_qty);
        div_rem <= '0;
        // error result: every field zero apart from status and last
        result  <= '{child_id:        '0,
                     child_parent_id: '0,
                     child_side:      1'b0,
                     child_qty:       '0,
                     child_time:      '0,
                     child_sequence:  '0,
                     status:          (bad_id ? tos_pkg::ST_BAD_ID
                                              : tos_pkg::ST_OVERFLOW),
                     last:            1'b1};
      end
      tos_pkg::S_DIV_QTY: begin
        if (div_last) begin
          div_num <= diff_mag;
          div_rem <= '0;
        end else begin
          div_num <= div_num_next;
          div_rem <= div_rem_next;
        end
      end
      tos_pkg::S_DIV_TIME: begin
        div_num <= div_num_next;
        div_rem <= div_rem_next;
        if (div_last) begin
          cur_id   <= first_id;
          cur_seq  <= first_seq;
          cur_time <= parent_start;
        end
      end
      tos_pkg::S_EMIT: begin
        result.child_id        <= cur_id;
        result.child_parent_id <= parent_id;
        result.child_side      <= parent_side;
        result.child_qty       <= base_share + tos_pkg::QTY_W'(extra_bit);
        result.child_time      <= cur_time;
        result.child_sequence  <= cur_seq;
        result.status          <= tos_pkg::ST_OK;
        result.last            <= emit_last;
        cur_id   <= cur_id + tos_pkg::ID_W'(1);
        cur_seq  <= cur_seq + tos_pkg::SEQ_W'(1);
        cur_time <= cur_time + slot_interval;
      end
      default: begin
        div_rem <= '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  // Error results always close their parent
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && (result.status != tos_pkg::ST_OK) |-> result.last)
    else $error("error result without last");

  // Good children come only from the emit phase
  a_ok_from_emit: assert property (@(posedge clk) disable iff (rst)
    result_strobe && (result.status == tos_pkg::ST_OK)
      |-> $past(state == tos_pkg::S_EMIT))
    else $error("child result outside emit phase");

  // Emission never runs past the slice count
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (state == tos_pkg::S_EMIT) |-> (slice_index < slice_total))
    else $error("slice index beyond slice total");

  // The block is free once the final result is shown
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.last |-> !busy)
    else $error("busy after final result");
`endif

endmodule

>>> tb/twap_order_slicer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// twap_order_slicer_test
// Self-checking bench for the order slicer. A short table of parent orders
// covers reset behaviour, field extremes, bad ids, overflow, clamped slice
// limits and reversed windows. Random bursts of parents under several slice
// limits follow. Every child is compared field by field, in order, with a
// built-in slicing predictor or with a fixed expected child.
// ----------------------------------------------------------------------------
module twap_order_slicer_test;

  localparam int SLICE_CAP     = 64;
  localparam int QUIET_LIMIT   = 2000;
  localparam int REPORT_LIMIT  = 10;
  localparam int DRAIN_CYCLES  = 120;
  localparam int DIRECTED_ROWS = 20;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 39;

  // How the children of a request are expected
  localparam int ROW_PREDICT = -1;
  localparam int ROW_SILENT  = 0;
  localparam int ROW_FIXED   = 1;
  localparam int CFG_KEEP    = -1;

  localparam logic [tos_pkg::ID_W-1:0]   ID_MAX   = '1;
  localparam logic [tos_pkg::QTY_W-1:0]  QTY_MAX  = '1;
  localparam logic [tos_pkg::SEQ_W-1:0]  SEQ_MAX  = '1;
  localparam logic [tos_pkg::TIME_W-1:0] TIME_MAX = '1;
  localparam tos_pkg::result_t           NO_CHILD = '0;

  typedef struct packed {
    int                cfg;
    int                mode;
    tos_pkg::request_t req;
    tos_pkg::result_t  want;
  } plan_row_t;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  tos_pkg::request_t             request;
  logic                          result_strobe;
  tos_pkg::result_t              result;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [tos_pkg::LIMIT_W-1:0]   cfg_data;

  tos_pkg::result_t              pending_children[$];
  logic [tos_pkg::LIMIT_W-1:0]   limit_shadow;
  int                            mode_now;
  tos_pkg::result_t              fixed_now;
  int                            mismatch_count;
  int                            quiet_cycles;
  plan_row_t                     plan[DIRECTED_ROWS];

  twap_order_slicer #(
    .MAX_SLICES(SLICE_CAP)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .result_strobe(result_strobe),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic tos_pkg::request_t mk_req(logic elig,
                                               logic [tos_pkg::QTY_W-1:0] qty,
                                               logic [tos_pkg::TIME_W-1:0] t0,
                                               logic [tos_pkg::TIME_W-1:0] t1,
                                               logic [tos_pkg::ID_W-1:0] pid,
                                               logic side,
                                               logic [tos_pkg::ID_W-1:0] fid,
                                               logic [tos_pkg::SEQ_W-1:0] fseq);
    tos_pkg::request_t r;
    r.eligible       = elig;
    r.remaining_qty  = qty;
    r.window_start   = t0;
    r.window_end     = t1;
    r.parent_id      = pid;
    r.order_side     = side;
    r.first_child_id = fid;
    r.first_sequence = fseq;
    return r;
  endfunction

  function automatic tos_pkg::result_t mk_child(logic [tos_pkg::ID_W-1:0] id,
                                                logic [tos_pkg::ID_W-1:0] pid,
                                                logic side,
                                                logic [tos_pkg::QTY_W-1:0] qty,
                                                logic [tos_pkg::TIME_W-1:0] tm,
                                                logic [tos_pkg::SEQ_W-1:0] seq,
                                                tos_pkg::status_t st, logic fin);
    tos_pkg::result_t c;
    c.child_id        = id;
    c.child_parent_id = pid;
    c.child_side      = side;
    c.child_qty       = qty;
    c.child_time      = tm;
    c.child_sequence  = seq;
    c.status          = st;
    c.last            = fin;
    return c;
  endfunction

  // Append one expected child to the tail of the queue
  function automatic void queue_child(tos_pkg::result_t c);
    pending_children.insert(pending_children.size(), c);
  endfunction

  // Split one parent into its expected children under the current limit
  function automatic void slice_parent(tos_pkg::request_t r);
    longint           lim;
    longint           qty;
    longint           n;
    longint           fid;
    longint           fseq;
    longint           share;
    longint           extra;
    longint           span;
    longint           step;
    longint           stamp;
    tos_pkg::result_t c;
    c = '0;
    c.last = 1'b1;
    if (!r.eligible)
      return;
    if (r.first_child_id == 0 || r.first_sequence == 0) begin
      c.status = tos_pkg::ST_BAD_ID;
      queue_child(c);
      return;
    end
    lim = limit_shadow;
    if (lim == 0)
      lim = 1;
    if (lim > SLICE_CAP)
      lim = SLICE_CAP;
    qty  = r.remaining_qty;
    fid  = r.first_child_id;
    fseq = r.first_sequence;
    n    = (qty < lim) ? qty : lim;
    if (n == 0 || n - 1 > longint'(ID_MAX) - fid ||
        n - 1 > longint'(SEQ_MAX) - fseq) begin
      c.status = tos_pkg::ST_OVERFLOW;
      queue_child(c);
      return;
    end
    share = qty / n;
    extra = qty % n;
    // signed window length, truncated toward zero
    span  = longint'({16'b0, r.window_end}) - longint'({16'b0, r.window_start});
    step  = span / n;
    for (longint i = 0; i < n; i++) begin
      stamp = longint'({16'b0, r.window_start}) + step * i;
      c.child_id        = tos_pkg::ID_W'(fid + i);
      c.child_parent_id = r.parent_id;
      c.child_side      = r.order_side;
      c.child_qty       = tos_pkg::QTY_W'(share + ((i < extra) ? 1 : 0));
      c.child_time      = stamp[tos_pkg::TIME_W-1:0];
      c.child_sequence  = tos_pkg::SEQ_W'(fseq + i);
      c.status          = tos_pkg::ST_OK;
      c.last            = (i + 1 == n);
      queue_child(c);
    end
  endfunction

  function automatic tos_pkg::request_t random_parent();
    tos_pkg::request_t r;
    logic [63:0]       wide;
    int                pick;
    r.eligible = ($urandom_range(0, 15) != 0);
    pick = $urandom_range(0, 9);
    if (pick <= 5)
      r.remaining_qty = $urandom_range(1, 80);
    else if (pick == 6)
      r.remaining_qty = $urandom;
    else if (pick == 7)
      r.remaining_qty = QTY_MAX - $urandom_range(0, 3);
    else
      r.remaining_qty = $urandom_range(0, 3);
    wide = {$urandom, $urandom};
    r.window_start = wide[tos_pkg::TIME_W-1:0];
    if ($urandom_range(0, 3) != 0)
      r.window_end = r.window_start + $urandom_range(0, 100000);
    else begin
      wide = {$urandom, $urandom};
      r.window_end = wide[tos_pkg::TIME_W-1:0];
    end
    r.parent_id  = $urandom;
    r.order_side = ($urandom_range(0, 1) != 0);
    pick = $urandom_range(0, 19);
    if (pick == 0)
      r.first_child_id = '0;
    else if (pick <= 2)
      r.first_child_id = ID_MAX - $urandom_range(0, 80);
    else
      r.first_child_id = $urandom;
    pick = $urandom_range(0, 19);
    if (pick == 0)
      r.first_sequence = '0;
    else if (pick <= 2)
      r.first_sequence = SEQ_MAX - $urandom_range(0, 80);
    else
      r.first_sequence = $urandom;
    return r;
  endfunction

  task automatic note_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  task automatic check_child(tos_pkg::result_t want, tos_pkg::result_t got);
    note_field("child_id", want.child_id, got.child_id);
    note_field("child_parent_id", want.child_parent_id, got.child_parent_id);
    note_field("child_side", want.child_side, got.child_side);
    note_field("child_qty", want.child_qty, got.child_qty);
    note_field("child_time", want.child_time, got.child_time);
    note_field("child_sequence", want.child_sequence, got.child_sequence);
    note_field("status", want.status, got.status);
    note_field("last", want.last, got.last);
  endtask

  // Track accepted requests, children and limit writes; watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      limit_shadow   = 1;
      quiet_cycles   = 0;
      mismatch_count = 0;
    end else begin
      quiet_cycles++;
      if (result_strobe) begin
        quiet_cycles = 0;
        if (pending_children.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: unexpected child %h", $time, result);
        end else
          check_child(pending_children.pop_front(), result);
      end
      if (start && !busy) begin
        quiet_cycles = 0;
        if (mode_now == ROW_PREDICT)
          slice_parent(request);
        else if (mode_now == ROW_FIXED)
          queue_child(fixed_now);
      end
      if (cfg_valid && cfg_ready) begin
        quiet_cycles = 0;
        limit_shadow = cfg_data;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Present one request and hold it until taken
  task automatic send_parent(tos_pkg::request_t r, int mode, tos_pkg::result_t want);
    @(negedge clk);
    mode_now  = mode;
    fixed_now = want;
    start   <= 1'b1;
    request <= r;
    do
      @(posedge clk);
    while (busy);
  endtask

  task automatic hold_off(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Drop start and wait until every expected child is back and the block is idle
  task automatic settle();
    hold_off(1);
    while (pending_children.size() != 0 || busy)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(logic [tos_pkg::LIMIT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do
      @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                          burst;
    logic [tos_pkg::LIMIT_W-1:0] lim;
    rst            = 1'b1;
    start          = 1'b0;
    request        = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    mode_now       = ROW_PREDICT;
    fixed_now      = '0;

    // Directed plan: limit change, expectation kind, request, fixed child
    plan[0]  = '{CFG_KEEP, ROW_SILENT, mk_req(0, 50, 10, 90, 32'h11, 0, 5, 5), NO_CHILD};
    plan[1]  = '{CFG_KEEP, ROW_FIXED, mk_req(1, 5, 100, 200, 32'hA, 1, 1, 1),
                 mk_child(1, 32'hA, 1, 5, 100, 1, tos_pkg::ST_OK, 1)};
    plan[2]  = '{CFG_KEEP, ROW_FIXED, mk_req(1, 9, 0, 50, 7, 0, 0, 3),
                 mk_child(0, 0, 0, 0, 0, 0, tos_pkg::ST_BAD_ID, 1)};
    plan[3]  = '{CFG_KEEP, ROW_FIXED, mk_req(1, 9, 0, 50, 7, 1, 3, 0),
                 mk_child(0, 0, 0, 0, 0, 0, tos_pkg::ST_BAD_ID, 1)};
    plan[4]  = '{CFG_KEEP, ROW_FIXED, mk_req(1, 0, 0, 50, 7, 0, 0, 0),
                 mk_child(0, 0, 0, 0, 0, 0, tos_pkg::ST_BAD_ID, 1)};
    plan[5]  = '{CFG_KEEP, ROW_FIXED, mk_req(1, 0, 0, 50, 7, 1, 4, 4),
                 mk_child(0, 0, 0, 0, 0, 0, tos_pkg::ST_OVERFLOW, 1)};
    plan[6]  = '{CFG_KEEP, ROW_FIXED,
                 mk_req(1, QTY_MAX, TIME_MAX, TIME_MAX, ID_MAX, 1, ID_MAX, SEQ_MAX),
                 mk_child(ID_MAX, ID_MAX, 1, QTY_MAX, TIME_MAX, SEQ_MAX,
                          tos_pkg::ST_OK, 1)};
    plan[7]  = '{64, ROW_PREDICT, mk_req(1, 1000, 0, 6400, 32'h100, 0, 32'h1000, 32'h2000),
                 NO_CHILD};
    plan[8]  = '{CFG_KEEP, ROW_PREDICT, mk_req(1, 3, 500, 530, 32'h22, 1, 20, 40), NO_CHILD};
    plan[9]  = '{CFG_KEEP, ROW_PREDICT, mk_req(1, 130, 1000, 2000, 32'h33, 0, 9, 9), NO_CHILD};
    // reversed window: negative interval
    plan[10] = '{CFG_KEEP, ROW_PREDICT, mk_req(1, 100, 5000, 100, 32'h44, 1, 2, 2), NO_CHILD};
    plan[11] = '{CFG_KEEP, ROW_FIXED, mk_req(1, 64, 0, 640, 5, 0, ID_MAX - 62, 1),
                 mk_child(0, 0, 0, 0, 0, 0, tos_pkg::ST_OVERFLOW, 1)};
    plan[12] = '{CFG_KEEP, ROW_PREDICT,
                 mk_req(1, 64, 0, 640, 5, 1, ID_MAX - 63, SEQ_MAX - 63), NO_CHILD};
    plan[13] = '{CFG_KEEP, ROW_FIXED, mk_req(1, 64, 0, 640, 5, 0, 1, SEQ_MAX - 10),
                 mk_child(0, 0, 0, 0, 0, 0, tos_pkg::ST_OVERFLOW, 1)};
    plan[14] = '{CFG_KEEP, ROW_FIXED,
                 mk_req(1, QTY_MAX, TIME_MAX, TIME_MAX, ID_MAX, 1, ID_MAX, SEQ_MAX),
                 mk_child(0, 0, 0, 0, 0, 0, tos_pkg::ST_OVERFLOW, 1)};
    // zero limit reads as one slice
    plan[15] = '{0, ROW_PREDICT, mk_req(1, 7, 30, 90, 32'h55, 0, 3, 3), NO_CHILD};
    // limits above the cap saturate
    plan[16] = '{127, ROW_PREDICT, mk_req(1, 200, 0, TIME_MAX, 32'h66, 1, 6, 6), NO_CHILD};
    plan[17] = '{CFG_KEEP, ROW_PREDICT, mk_req(1, 65, TIME_MAX, 0, 32'h77, 0, 7, 7), NO_CHILD};
    plan[18] = '{100, ROW_PREDICT, mk_req(1, 64, 12, 12, 0, 0, 8, 8), NO_CHILD};
    plan[19] = '{2, ROW_PREDICT, mk_req(1, 3, 0, 5, 32'h88, 1, 10, 10), NO_CHILD};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed plan
    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      if (plan[k].cfg != CFG_KEEP) begin
        settle();
        write_limit(tos_pkg::LIMIT_W'(plan[k].cfg));
      end
      send_parent(plan[k].req, plan[k].mode, plan[k].want);
      hold_off($urandom_range(0, 3));
    end

    // Random bursts of parents, one slice limit per phase
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: lim = tos_pkg::LIMIT_W'(SLICE_CAP);
        1: lim = 1;
        2: lim = 0;
        3: lim = '1;
        default: lim = tos_pkg::LIMIT_W'($urandom_range(0, 127));
      endcase
      write_limit(lim);
      burst = $urandom_range(1, 8);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        send_parent(random_parent(), ROW_PREDICT, NO_CHILD);
        if (p == 4 && j == PHASE_ITEMS / 2)
          settle();
        else if (p != 5) begin
          // back-to-back requests in bursts, random gaps between them
          burst--;
          if (burst == 0) begin
            hold_off($urandom_range(1, 10));
            burst = $urandom_range(1, 8);
          end
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_children.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
